>>> src/timer_min_heap_assert.svh
`ifndef TIMER_MIN_HEAP_ASSERT_SVH
`define TIMER_MIN_HEAP_ASSERT_SVH

// same-cycle implication
`define TMH_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define TMH_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> src/tmh_pkg.sv
package tmh_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_ADJUST = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_EXPIRED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam int OUT_MAX = 64;
    localparam int NW      = $clog2(OUT_MAX + 1);

    localparam logic [3:0] DP_NOP        = 4'd0;
    localparam logic [3:0] DP_START_INS  = 4'd1;
    localparam logic [3:0] DP_FIND_START = 4'd2;
    localparam logic [3:0] DP_RD_POS     = 4'd3;
    localparam logic [3:0] DP_FIND_NEXT  = 4'd4;
    localparam logic [3:0] DP_FOUND_ADJ  = 4'd5;
    localparam logic [3:0] DP_FOUND_DEL  = 4'd6;
    localparam logic [3:0] DP_DEL_TAIL   = 4'd7;
    localparam logic [3:0] DP_LOAD_HOLD  = 4'd8;
    localparam logic [3:0] DP_RD_PARENT  = 4'd9;
    localparam logic [3:0] DP_MOVE_UP    = 4'd10;
    localparam logic [3:0] DP_RD_CHILD   = 4'd11;
    localparam logic [3:0] DP_MOVE_DOWN  = 4'd12;
    localparam logic [3:0] DP_WRITE_HOLD = 4'd13;
    localparam logic [3:0] DP_TICK_START = 4'd14;
    localparam logic [3:0] DP_TICK_POP   = 4'd15;

    localparam logic [1:0] SEL_NONE  = 2'd0;
    localparam logic [1:0] SEL_LEFT  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic       emit;
        logic [1:0] status;
        logic       use_pend;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic       count_zero;
        logic       full;
        logic       one_left;
        logic       pos_at_count;
        logic       pos_root;
        logic       last_at_pos;
        logic       moved;
        logic       up_less;
        logic       left_none;
        logic [1:0] down_sel;
        logic       id_match;
        logic       due;
        logic       pend_valid;
        logic       n_max;
    } t_dp_stat;

endpackage

>>> src/tmh_dp.sv
module tmh_dp
    import tmh_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_latch,
    input  logic [7:0]           i_timer_id,
    input  logic [TIME_BITS-1:0] i_expire_time,
    input  logic [TIME_BITS-1:0] i_current_time,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic                 o_strobe,
    output logic [7:0]           o_expired_id,
    output logic [1:0]           o_status,
    output logic                 o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [TIME_BITS-1:0] mem_time [DEPTH];
    logic [7:0]           mem_id   [DEPTH];

    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_pos, n_pos;
    logic [CW-1:0]        r_left, n_left;
    logic                 r_right_ok, n_right_ok;
    logic                 r_moved, n_moved;
    logic [TIME_BITS-1:0] r_hold_time, n_hold_time;
    logic [7:0]           r_hold_id, n_hold_id;
    logic [7:0]           r_id;
    logic [TIME_BITS-1:0] r_exp;
    logic [TIME_BITS-1:0] r_cur;
    logic [NW-1:0]        r_n, n_n;
    logic                 r_pend_valid, n_pend_valid;
    logic [7:0]           r_pend_id, n_pend_id;
    logic [TIME_BITS-1:0] r_rda_time, r_rdb_time;
    logic [7:0]           r_rda_id, r_rdb_id;
    logic                 r_strobe;
    logic [7:0]           r_expired_id;
    logic [1:0]           r_status;
    logic                 r_last;

    logic [CW:0]          w_left;
    logic [CW-1:0]        w_parent;
    logic [CW-1:0]        w_count_m1;
    logic [AW-1:0]        w_addr_a, w_addr_b;
    logic                 w_rd;
    logic                 w_we;
    logic [TIME_BITS-1:0] w_wr_time;
    logic [7:0]           w_wr_id;
    logic                 w_left_lt;
    logic [TIME_BITS-1:0] w_best_time;
    logic                 w_right_lt;
    logic [1:0]           w_sel;
    logic [CW-1:0]        w_right;

    assign w_left     = {r_pos, 1'b1};
    assign w_parent   = (r_pos - CW'(1)) >> 1;
    assign w_count_m1 = r_count - CW'(1);
    assign w_right    = r_left + CW'(1);

    assign w_left_lt   = r_rda_time < r_hold_time;
    assign w_best_time = w_left_lt ? r_rda_time : r_hold_time;
    assign w_right_lt  = r_right_ok && (r_rdb_time < w_best_time);
    assign w_sel       = w_right_lt ? SEL_RIGHT : (w_left_lt ? SEL_LEFT : SEL_NONE);

    always_comb begin
        o_stat.count_zero   = (r_count == '0);
        o_stat.full         = (r_count == CW'(DEPTH));
        o_stat.one_left     = (r_count == CW'(1));
        o_stat.pos_at_count = (r_pos == r_count);
        o_stat.pos_root     = (r_pos == '0);
        o_stat.last_at_pos  = (r_pos == w_count_m1);
        o_stat.moved        = r_moved;
        o_stat.up_less      = r_hold_time < r_rda_time;
        o_stat.left_none    = (w_left >= {1'b0, r_count});
        o_stat.down_sel     = w_sel;
        o_stat.id_match     = (r_rda_id == r_id);
        o_stat.due          = (r_rda_time <= r_cur);
        o_stat.pend_valid   = r_pend_valid;
        o_stat.n_max        = (r_n == NW'(OUT_MAX));
    end

    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_left       = r_left;
        n_right_ok   = r_right_ok;
        n_moved      = r_moved;
        n_hold_time  = r_hold_time;
        n_hold_id    = r_hold_id;
        n_n          = r_n;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        w_addr_a     = r_pos[AW-1:0];
        w_addr_b     = w_right[AW-1:0];
        w_rd         = 1'b0;
        w_we         = 1'b0;
        w_wr_time    = r_hold_time;
        w_wr_id      = r_hold_id;
        case (i_cmd.op)
            DP_START_INS: begin
                n_pos       = r_count;
                n_count     = r_count + CW'(1);
                n_hold_time = r_exp;
                n_hold_id   = r_id;
                n_moved     = 1'b1;
            end
            DP_FIND_START: n_pos = '0;
            DP_RD_POS: begin
                w_rd     = 1'b1;
                w_addr_a = r_pos[AW-1:0];
            end
            DP_FIND_NEXT: n_pos = r_pos + CW'(1);
            DP_FOUND_ADJ: begin
                n_hold_time = r_exp;
                n_hold_id   = r_id;
                n_moved     = 1'b0;
            end
            DP_FOUND_DEL: begin
                n_count  = w_count_m1;
                n_moved  = 1'b0;
                w_rd     = 1'b1;
                w_addr_a = w_count_m1[AW-1:0];
            end
            DP_DEL_TAIL: n_count = w_count_m1;
            DP_LOAD_HOLD: begin
                n_hold_time = r_rda_time;
                n_hold_id   = r_rda_id;
            end
            DP_RD_PARENT: begin
                w_rd     = 1'b1;
                w_addr_a = w_parent[AW-1:0];
            end
            DP_MOVE_UP: begin
                w_we      = 1'b1;
                w_wr_time = r_rda_time;
                w_wr_id   = r_rda_id;
                n_pos     = w_parent;
                n_moved   = 1'b1;
            end
            DP_RD_CHILD: begin
                w_rd       = 1'b1;
                w_addr_a   = w_left[AW-1:0];
                w_addr_b   = AW'(w_left + (CW+1)'(1));
                n_left     = w_left[CW-1:0];
                n_right_ok = (w_left + (CW+1)'(1)) < {1'b0, r_count};
            end
            DP_MOVE_DOWN: begin
                w_we = 1'b1;
                if (w_sel == SEL_RIGHT) begin
                    w_wr_time = r_rdb_time;
                    w_wr_id   = r_rdb_id;
                    n_pos     = w_right;
                end else begin
                    w_wr_time = r_rda_time;
                    w_wr_id   = r_rda_id;
                    n_pos     = r_left;
                end
            end
            DP_WRITE_HOLD: begin
                w_we  = 1'b1;
                n_pos = '0;
            end
            DP_TICK_START: begin
                n_n          = '0;
                n_pend_valid = 1'b0;
                n_pos        = '0;
                w_rd         = 1'b1;
                w_addr_a     = '0;
            end
            DP_TICK_POP: begin
                n_pend_valid = 1'b1;
                n_pend_id    = r_rda_id;
                n_n          = r_n + NW'(1);
                n_count      = w_count_m1;
                n_pos        = '0;
                n_moved      = 1'b1;
                w_rd         = 1'b1;
                w_addr_a     = w_count_m1[AW-1:0];
            end
            default: begin
                if (r_pos == '0) begin
                    w_addr_a = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_time[r_pos[AW-1:0]] <= w_wr_time;
            mem_id[r_pos[AW-1:0]]   <= w_wr_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd || (i_cmd.op == DP_NOP && r_count != '0)) begin
            r_rda_time <= mem_time[w_addr_a];
            r_rda_id   <= mem_id[w_addr_a];
            r_rdb_time <= mem_time[w_addr_b];
            r_rdb_id   <= mem_id[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
            r_n          <= '0;
            r_moved      <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= i_cmd.emit;
            r_n          <= n_n;
            r_moved      <= n_moved;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_left      <= n_left;
        r_right_ok  <= n_right_ok;
        r_hold_time <= n_hold_time;
        r_hold_id   <= n_hold_id;
        r_pend_id   <= n_pend_id;
        if (i_latch) begin
            r_id  <= i_timer_id;
            r_exp <= i_expire_time;
            r_cur <= i_current_time;
        end
        r_expired_id <= i_cmd.use_pend ? r_pend_id : 8'd0;
        r_status     <= i_cmd.status;
        r_last       <= i_cmd.last;
    end

    assign o_strobe     = r_strobe;
    assign o_expired_id = r_expired_id;
    assign o_status     = r_status;
    assign o_last       = r_last;

endmodule

>>> src/tmh_ctrl.sv
module tmh_ctrl
    import tmh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_command,
    input  t_dp_stat   i_stat,
    output logic       o_busy,
    output logic       o_latch,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_FIND_RD  = 4'd2;
    localparam logic [3:0] S_FIND_CHK = 4'd3;
    localparam logic [3:0] S_LOAD     = 4'd4;
    localparam logic [3:0] S_UP_RD    = 4'd5;
    localparam logic [3:0] S_UP_CHK   = 4'd6;
    localparam logic [3:0] S_DN_RD    = 4'd7;
    localparam logic [3:0] S_DN_CHK   = 4'd8;
    localparam logic [3:0] S_WRITE    = 4'd9;
    localparam logic [3:0] S_TICK_RD  = 4'd10;
    localparam logic [3:0] S_TICK_CHK = 4'd11;
    localparam logic [3:0] S_TICK_END = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_op, n_op;

    assign o_busy  = (r_state != S_IDLE);
    assign o_latch = (r_state == S_IDLE) && i_start;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '{op: DP_NOP, emit: 1'b0, status: ST_DONE, use_pend: 1'b0, last: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_command;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_op)
                    CMD_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_FULL;
                            o_cmd.last   = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.op = DP_START_INS;
                            n_state  = S_UP_RD;
                        end
                    end
                    CMD_TICK: begin
                        o_cmd.op = DP_TICK_START;
                        n_state  = S_TICK_RD;
                    end
                    default: begin
                        o_cmd.op = DP_FIND_START;
                        n_state  = S_FIND_RD;
                    end
                endcase
            end
            S_FIND_RD: begin
                if (i_stat.pos_at_count) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_NOTFOUND;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = DP_RD_POS;
                    n_state  = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (!i_stat.id_match) begin
                    o_cmd.op = DP_FIND_NEXT;
                    n_state  = S_FIND_RD;
                end else if (r_op == CMD_ADJUST) begin
                    o_cmd.op = DP_FOUND_ADJ;
                    n_state  = S_UP_RD;
                end else if (i_stat.last_at_pos) begin
                    o_cmd.op   = DP_DEL_TAIL;
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.op = DP_FOUND_DEL;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op = DP_LOAD_HOLD;
                n_state  = (r_op == CMD_TICK) ? S_DN_RD : S_UP_RD;
            end
            S_UP_RD: begin
                if (i_stat.pos_root) begin
                    n_state = i_stat.moved ? S_WRITE : S_DN_RD;
                end else begin
                    o_cmd.op = DP_RD_PARENT;
                    n_state  = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (i_stat.up_less) begin
                    o_cmd.op = DP_MOVE_UP;
                    n_state  = S_UP_RD;
                end else begin
                    n_state = i_stat.moved ? S_WRITE : S_DN_RD;
                end
            end
            S_DN_RD: begin
                if (i_stat.left_none) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.op = DP_RD_CHILD;
                    n_state  = S_DN_CHK;
                end
            end
            S_DN_CHK: begin
                if (i_stat.down_sel == SEL_NONE) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.op = DP_MOVE_DOWN;
                    n_state  = S_DN_RD;
                end
            end
            S_WRITE: begin
                o_cmd.op = DP_WRITE_HOLD;
                if (r_op == CMD_TICK) begin
                    n_state = S_TICK_RD;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_TICK_RD: begin
                if (i_stat.count_zero || i_stat.n_max) begin
                    n_state = S_TICK_END;
                end else begin
                    o_cmd.op = DP_RD_POS;
                    n_state  = S_TICK_CHK;
                end
            end
            S_TICK_CHK: begin
                if (i_stat.due) begin
                    o_cmd.op       = DP_TICK_POP;
                    o_cmd.emit     = i_stat.pend_valid;
                    o_cmd.status   = ST_EXPIRED;
                    o_cmd.use_pend = 1'b1;
                    n_state        = i_stat.one_left ? S_TICK_END : S_LOAD;
                end else begin
                    n_state = S_TICK_END;
                end
            end
            S_TICK_END: begin
                o_cmd.emit     = 1'b1;
                o_cmd.last     = 1'b1;
                o_cmd.use_pend = i_stat.pend_valid;
                o_cmd.status   = i_stat.pend_valid ? ST_EXPIRED : ST_DONE;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= CMD_INSERT;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

>>> src/timer_min_heap.sv
// channel  | ports                                              | beat
// command  | i_start, o_busy, i_command, i_timer_id,            | i_start && !o_busy
//          | i_expire_time, i_current_time                      |
// result   | o_strobe, o_expired_id, o_status, o_last           | o_strobe, one cycle
//
// Insert sifts the new entry up from the tail, with one parent read and compare per level.
// Adjust and delete add a linear search of the entries for the id before any sift.
// Tick pops up to 64 expired timers, sifting the tail entry down from the root after each.
// Reset clears the entry count but not the heap memory; no clearing pass runs.
// Results cannot be stalled; busy drops in the cycle the last result is on the ports.
module timer_min_heap
    import tmh_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_timer_id,
    input  logic [TIME_BITS-1:0] i_expire_time,
    input  logic [TIME_BITS-1:0] i_current_time,
    output logic                 o_strobe,
    output logic [7:0]           o_expired_id,
    output logic [1:0]           o_status,
    output logic                 o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_latch;

    tmh_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_busy    (o_busy),
        .o_latch   (w_latch),
        .o_cmd     (w_cmd)
    );

    tmh_dp #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_latch        (w_latch),
        .i_timer_id     (i_timer_id),
        .i_expire_time  (i_expire_time),
        .i_current_time (i_current_time),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_strobe       (o_strobe),
        .o_expired_id   (o_expired_id),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

>>> src/tmh_chk.sv
`include "timer_min_heap_assert.svh"

module tmh_chk
    import tmh_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_strobe,
    input logic [7:0] o_expired_id,
    input logic [1:0] o_status,
    input logic       o_last
);

    `TMH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `TMH_ASSERT_NOW(a_more_busy, i_clk, i_rst_n, o_strobe && !o_last, o_busy)
    `TMH_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_strobe && o_last, !o_busy)
    `TMH_ASSERT_NOW(a_single_last, i_clk, i_rst_n, o_strobe && o_status != ST_EXPIRED, o_last)
    `TMH_ASSERT_NOW(a_id_zero, i_clk, i_rst_n, o_strobe && o_status != ST_EXPIRED,
                    o_expired_id == 8'd0)

endmodule

bind timer_min_heap tmh_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_strobe     (o_strobe),
    .o_expired_id (o_expired_id),
    .o_status     (o_status),
    .o_last       (o_last)
);

>>> tb/tb.sv
module tb
    import tmh_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] id;
        logic [1:0] status;
        logic       last;
    } t_timer_result;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  id;
        logic [31:0] exp_t;
        logic [31:0] cur_t;
        bit          has_result;
        logic [1:0]  status;
    } t_cmd_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_command;
    logic [7:0]  i_timer_id;
    logic [31:0] i_expire_time;
    logic [31:0] i_current_time;
    logic        o_strobe;
    logic [7:0]  o_expired_id;
    logic [1:0]  o_status;
    logic        o_last;

    timer_min_heap DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_command(i_command), .i_timer_id(i_timer_id),
        .i_expire_time(i_expire_time), .i_current_time(i_current_time),
        .o_strobe(o_strobe), .o_expired_id(o_expired_id),
        .o_status(o_status), .o_last(o_last)
    );

    logic [31:0] mdl_times [HEAP_DEPTH];
    logic [7:0]  mdl_ids [HEAP_DEPTH];
    int          mdl_count;
    t_timer_result pending_results[$];
    int errors;
    int cycles;
    int n_expired;
    int n_beats;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timer_min_heap regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: id %0d status %0d", o_expired_id,
                       o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_expired_id !== want.id) begin
                    $error("expired_id: expected %0d actual %0d", want.id, o_expired_id);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_status);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d actual %0d", want.last, o_last);
                    errors++;
                end
                if (o_status == ST_EXPIRED) n_expired++;
            end
        end
    end

    function automatic void swap_slots(int a, int b);
        logic [31:0] t;
        logic [7:0]  d;
        t = mdl_times[a]; d = mdl_ids[a];
        mdl_times[a] = mdl_times[b]; mdl_ids[a] = mdl_ids[b];
        mdl_times[b] = t; mdl_ids[b] = d;
    endfunction

    function automatic void sift_up(int pos);
        int parent;
        while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (mdl_times[pos] < mdl_times[parent]) begin
                swap_slots(pos, parent);
                pos = parent;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void sift_down(int pos);
        int l;
        int best;
        while (pos < mdl_count) begin
            l = 2 * pos + 1;
            best = pos;
            if (l < mdl_count && mdl_times[l] < mdl_times[best]) best = l;
            if (l + 1 < mdl_count && mdl_times[l + 1] < mdl_times[best]) best = l + 1;
            if (best == pos) break;
            swap_slots(pos, best);
            pos = best;
        end
    endfunction

    function automatic int find_timer(logic [7:0] id);
        for (int k = 0; k < mdl_count; k++)
            if (mdl_ids[k] == id) return k;
        return -1;
    endfunction

    function automatic void push_result(logic [7:0] id, logic [1:0] st, logic lst);
        t_timer_result r;
        r.id = id; r.status = st; r.last = lst;
        pending_results = {pending_results, r};
    endfunction

    function automatic void predict_timer_cmd(logic [1:0] cmd, logic [7:0] id,
                                              logic [31:0] exp_t, logic [31:0] cur_t);
        int pos;
        int n;
        case (cmd)
            CMD_INSERT: begin
                if (mdl_count >= HEAP_DEPTH) begin
                    push_result(8'd0, ST_FULL, 1'b1);
                end else begin
                    mdl_times[mdl_count] = exp_t;
                    mdl_ids[mdl_count] = id;
                    mdl_count++;
                    sift_up(mdl_count - 1);
                    push_result(8'd0, ST_DONE, 1'b1);
                end
            end
            CMD_ADJUST: begin
                pos = find_timer(id);
                if (pos < 0) begin
                    push_result(8'd0, ST_NOTFOUND, 1'b1);
                end else begin
                    mdl_times[pos] = exp_t;
                    sift_up(pos);
                    sift_down(pos);
                    push_result(8'd0, ST_DONE, 1'b1);
                end
            end
            CMD_DELETE: begin
                pos = find_timer(id);
                if (pos < 0) begin
                    push_result(8'd0, ST_NOTFOUND, 1'b1);
                end else begin
                    mdl_count--;
                    if (pos != mdl_count) begin
                        mdl_times[pos] = mdl_times[mdl_count];
                        mdl_ids[pos] = mdl_ids[mdl_count];
                        sift_up(pos);
                        sift_down(pos);
                    end
                    push_result(8'd0, ST_DONE, 1'b1);
                end
            end
            default: begin
                n = 0;
                while (n < OUT_MAX && mdl_count > 0 && mdl_times[0] <= cur_t) begin
                    push_result(mdl_ids[0], ST_EXPIRED, 1'b0);
                    n++;
                    mdl_count--;
                    if (mdl_count > 0) begin
                        mdl_times[0] = mdl_times[mdl_count];
                        mdl_ids[0] = mdl_ids[mdl_count];
                        sift_down(0);
                    end
                end
                if (n == 0) push_result(8'd0, ST_DONE, 1'b1);
                else pending_results[$].last = 1'b1;
            end
        endcase
    endfunction

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        repeat (g) @(negedge i_clk);
    endtask

    task automatic send_beat(logic [1:0] cmd, logic [7:0] id, logic [31:0] exp_t,
                             logic [31:0] cur_t);
        i_command = cmd;
        i_timer_id = id;
        i_expire_time = exp_t;
        i_current_time = cur_t;
        i_start = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_timer_cmd(cmd, id, exp_t, cur_t);
        n_beats++;
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_time(logic [31:0] base);
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return base + $urandom_range(0, 200);
        endcase
    endfunction

    t_cmd_row directed[$];

    function automatic void add_row(logic [1:0] c, logic [7:0] id, logic [31:0] e,
                                    logic [31:0] t, bit h, logic [1:0] s);
        t_cmd_row r;
        r.cmd = c; r.id = id; r.exp_t = e; r.cur_t = t; r.has_result = h; r.status = s;
        directed = {directed, r};
    endfunction

    initial begin
        logic [1:0]  cmd;
        logic [7:0]  id;
        logic [31:0] now;
        int          rnd;
        errors = 0; cycles = 0; mdl_count = 0; n_expired = 0; n_beats = 0;
        i_rst_n = 1'b0; i_start = 1'b0; i_command = CMD_INSERT; i_timer_id = 8'd0;
        i_expire_time = 32'd0; i_current_time = 32'd0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(CMD_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF, 1, ST_DONE);
        add_row(CMD_ADJUST, 8'd5, 32'd1, 32'd0, 1, ST_NOTFOUND);
        add_row(CMD_DELETE, 8'd5, 32'd1, 32'd0, 1, ST_NOTFOUND);
        add_row(CMD_INSERT, 8'd255, 32'hFFFF_FFFF, 32'd0, 1, ST_DONE);
        add_row(CMD_INSERT, 8'd0, 32'd0, 32'd0, 1, ST_DONE);
        add_row(CMD_INSERT, 8'd7, 32'd100, 32'd0, 0, ST_DONE);
        add_row(CMD_INSERT, 8'd7, 32'd100, 32'd0, 0, ST_DONE);
        add_row(CMD_INSERT, 8'd9, 32'd50, 32'd0, 0, ST_DONE);
        add_row(CMD_TICK, 8'd0, 32'd0, 32'd0, 0, ST_DONE);
        add_row(CMD_ADJUST, 8'd7, 32'd10, 32'd0, 0, ST_DONE);
        add_row(CMD_ADJUST, 8'd255, 32'd20, 32'd0, 0, ST_DONE);
        add_row(CMD_DELETE, 8'd9, 32'd0, 32'd0, 0, ST_DONE);
        add_row(CMD_TICK, 8'd0, 32'd0, 32'd9, 0, ST_DONE);
        add_row(CMD_TICK, 8'd0, 32'd0, 32'd100, 0, ST_DONE);
        add_row(CMD_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF, 0, ST_DONE);
        add_row(CMD_DELETE, 8'd7, 32'd0, 32'd0, 1, ST_NOTFOUND);
        foreach (directed[k]) begin
            send_beat(directed[k].cmd, directed[k].id, directed[k].exp_t, directed[k].cur_t);
            if (directed[k].has_result && pending_results[$].status !== directed[k].status) begin
                $error("status: expected %0d actual %0d (table row %0d)",
                       directed[k].status, pending_results[$].status, k);
                errors++;
            end
            idle_gap();
        end

        for (int k = 0; k < HEAP_DEPTH; k++) begin
            send_beat(CMD_INSERT, k[7:0], $urandom_range(0, 1000), 32'd0);
            idle_gap();
        end
        send_beat(CMD_INSERT, 8'd200, 32'd5, 32'd0);
        if (pending_results[$].status !== ST_FULL) begin
            $error("status: expected %0d actual %0d", ST_FULL, pending_results[$].status);
            errors++;
        end
        send_beat(CMD_DELETE, 8'd63, 32'd0, 32'd0);
        send_beat(CMD_ADJUST, 8'd0, 32'hFFFF_FFFF, 32'd0);
        drain();
        send_beat(CMD_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);

        now = 32'd1000;
        for (int k = 0; k < 286; k++) begin
            rnd = $urandom_range(0, 99);
            if (rnd < 40) cmd = CMD_INSERT;
            else if (rnd < 55) cmd = CMD_ADJUST;
            else if (rnd < 70) cmd = CMD_DELETE;
            else cmd = CMD_TICK;
            if ((cmd == CMD_ADJUST || cmd == CMD_DELETE) && mdl_count > 0 &&
                $urandom_range(0, 3) != 0)
                id = mdl_ids[$urandom_range(0, mdl_count - 1)];
            else
                id = 8'($urandom);
            if (cmd == CMD_TICK) now = now + $urandom_range(0, 150);
            send_beat(cmd, id, rand_time(now), ($urandom_range(0, 19) == 0) ? $urandom : now);
            if (k % 97 == 50) drain();
            idle_gap();
        end
        drain();
        repeat (300) @(negedge i_clk);

        $display("beats sent: %0d, timers expired: %0d", n_beats, n_expired);
        $display("covered insert/adjust/delete/tick, full heap, absent ids, duplicates");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("timer_min_heap regression: pass");
        end else begin
            $display("timer_min_heap regression: fail");
        end
        $finish;
    end
endmodule
